@@ design/dsf_pkg.sv @@
// Shared types and constants for the duplicate-refusing shift queue.
// Used by dsf_cell, dedup_shift_fifo_top and the testbench; depends on nothing else.
`default_nettype none

package dsf_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int CMD_W     = 2;
	localparam int ITEM_W    = 32;
	localparam int POS_W     = 4;
	localparam int READ_W    = 32;
	localparam int STAT_W    = 3;
	localparam int OCC_W     = 5;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ  = 2'd0,
		CMD_DEQ  = 2'd1,
		CMD_PEEK = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 3'd0,
		ST_DUP   = 3'd1,
		ST_FULL  = 3'd2,
		ST_EMPTY = 3'd3,
		ST_RANGE = 3'd4
	} status_t;

	typedef struct packed {
		logic enq;
		logic deq;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ design/dsf_cell.sv @@
// One queue cell: holds one entry, compares it with the incoming word,
// loads it at the tail on enqueue and takes its neighbour's on dequeue.
// Depends on dsf_pkg.
`default_nettype none

module dsf_cell #(
	parameter int DATA_WIDTH = dsf_pkg::DATA_WIDTH_DEF,
	parameter int CNT_W      = 5,
	parameter int IDX        = 0
) (
	input  wire logic                   clk,
	input  wire dsf_pkg::cell_ctrl_t    ctrl,
	input  wire logic [CNT_W-1:0]       count,
	input  wire logic [DATA_WIDTH-1:0]  item,
	input  wire logic [DATA_WIDTH-1:0]  next_entry,
	output logic      [DATA_WIDTH-1:0]  entry,
	output logic                        match
);

	logic [DATA_WIDTH-1:0] entry_q;
	logic                  occupied;
	logic                  at_tail;

	assign occupied = count > CNT_W'(IDX);
	assign at_tail  = count == CNT_W'(IDX);
	assign match    = occupied && (entry_q == item);
	assign entry    = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.deq) begin
			entry_q <= next_entry;
		end else if (ctrl.enq && at_tail) begin
			entry_q <= item;
		end
	end

endmodule

`default_nettype wire

@@ design/dedup_shift_fifo_top.sv @@
// Top level of the duplicate-refusing shift queue: a row of dsf_cell
// instances, the occupancy counter, command decode and the result register.
// Depends on dsf_pkg and dsf_cell.
//
//  channel  | direction | tdata                              | tuser
//  s_axis   | in        | item_value[31:0] peek_position[35:32] | command[1:0]
//  m_axis   | out       | read_value[31:0] occupancy[36:32]  | status[2:0]
//
// Each command is decoded, checked against every cell and committed in the
// cycle it is accepted; its result appears in the output register on the
// next cycle, so one command is taken per cycle while m_axis keeps up. The
// duplicate search is one compare in each cell joined by a wide OR. Reset
// empties the queue at once. A new command is taken whenever the output
// register is empty or its word is being taken in the same cycle.
`default_nettype none

module dedup_shift_fifo_top #(
	parameter int DEPTH      = dsf_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = dsf_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// item_value[31:0], peek_position[35:32], zero padding above.
	input  wire logic [dsf_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// command[1:0].
	input  wire logic [dsf_pkg::CMD_W-1:0]       s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// read_value[31:0], occupancy[36:32], zero padding above.
	output logic      [dsf_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	// status[2:0].
	output logic      [dsf_pkg::STAT_W-1:0]      m_axis_tuser
);

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (CNT_W > dsf_pkg::POS_W) ? CNT_W : dsf_pkg::POS_W;
	localparam int OCC_XW = (CNT_W > dsf_pkg::OCC_W) ? CNT_W : dsf_pkg::OCC_W;
	localparam int PEEK_N = (DEPTH < (1 << dsf_pkg::POS_W)) ? DEPTH : (1 << dsf_pkg::POS_W);

	logic [DATA_WIDTH-1:0]          entry_w [DEPTH];
	logic [DEPTH-1:0]               match_w;
	logic [DATA_WIDTH-1:0]          item_w;
	logic [dsf_pkg::POS_W-1:0]      pos_w;
	logic [DATA_WIDTH-1:0]          peek_w;
	logic [dsf_pkg::READ_W-1:0]     read_w;
	logic                           accept;
	logic                           dup;
	logic                           full;
	dsf_pkg::cell_ctrl_t            ctrl;
	dsf_pkg::status_t               st_d;
	logic [DATA_WIDTH-1:0]          rd_d;
	logic [CNT_W-1:0]               cnt_d;
	logic [OCC_XW-1:0]              occ_x;

	logic [CNT_W-1:0]               count_q;
	logic                           out_valid_q;
	logic [dsf_pkg::READ_W-1:0]     rd_q;
	logic [dsf_pkg::STAT_W-1:0]     st_q;
	logic [dsf_pkg::OCC_W-1:0]      occ_q;

	assign pos_w = s_axis_tdata[dsf_pkg::ITEM_W +: dsf_pkg::POS_W];

	generate
		if (DATA_WIDTH >= dsf_pkg::ITEM_W) begin : g_item_wide
			assign item_w = DATA_WIDTH'(s_axis_tdata[dsf_pkg::ITEM_W-1:0]);
		end else begin : g_item_narrow
			assign item_w = s_axis_tdata[DATA_WIDTH-1:0];
		end
		if (DATA_WIDTH >= dsf_pkg::READ_W) begin : g_read_wide
			assign read_w = rd_d[dsf_pkg::READ_W-1:0];
		end else begin : g_read_narrow
			assign read_w = dsf_pkg::READ_W'(rd_d);
		end
	endgenerate

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] next_w;
		if (i == DEPTH - 1) begin : g_last
			assign next_w = entry_w[i];
		end else begin : g_mid
			assign next_w = entry_w[i+1];
		end
		dsf_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CNT_W      (CNT_W),
			.IDX        (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (count_q),
			.item       (item_w),
			.next_entry (next_w),
			.entry      (entry_w[i]),
			.match      (match_w[i])
		);
	end

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign dup           = |match_w;
	assign full          = count_q == CNT_W'(DEPTH);

	always_comb begin
		peek_w = '0;
		for (int i = 0; i < PEEK_N; i++) begin
			if (pos_w == dsf_pkg::POS_W'(i)) begin
				peek_w = entry_w[i];
			end
		end
	end

	always_comb begin
		st_d     = dsf_pkg::ST_OK;
		rd_d     = '0;
		cnt_d    = count_q;
		ctrl.enq = 1'b0;
		ctrl.deq = 1'b0;
		case (dsf_pkg::cmd_t'(s_axis_tuser))
			dsf_pkg::CMD_ENQ: begin
				if (dup) begin
					st_d = dsf_pkg::ST_DUP;
				end else if (full) begin
					st_d = dsf_pkg::ST_FULL;
				end else begin
					ctrl.enq = accept;
					cnt_d    = count_q + CNT_W'(1);
				end
			end
			dsf_pkg::CMD_DEQ: begin
				if (count_q == '0) begin
					st_d = dsf_pkg::ST_EMPTY;
				end else begin
					rd_d     = entry_w[0];
					ctrl.deq = accept;
					cnt_d    = count_q - CNT_W'(1);
				end
			end
			dsf_pkg::CMD_PEEK: begin
				if (CMP_W'(pos_w) >= CMP_W'(count_q)) begin
					st_d = dsf_pkg::ST_RANGE;
				end else begin
					rd_d = peek_w;
				end
			end
			default: begin
			end
		endcase
	end

	assign occ_x = OCC_XW'(cnt_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q  <= read_w;
			st_q  <= st_d;
			occ_q <= occ_x[dsf_pkg::OCC_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(dsf_pkg::M_TDATA_W - dsf_pkg::READ_W - dsf_pkg::OCC_W){1'b0}},
		occ_q, rd_q};
	assign m_axis_tuser  = st_q;

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for dedup_shift_fifo_top, the duplicate-refusing shift queue.
// A scoreboard class predicts each result word from its own copy of the queue.
// Depends on dsf_pkg and the RTL of the block; nothing else.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUE_DEPTH = dsf_pkg::DEPTH_DEF;
	localparam logic [dsf_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 1920;
	localparam int POOL_SIZE = 24;
	localparam int HOLD_AT = 900;
	localparam int HOLD_CYCLES = 200;

	typedef struct packed {
		logic [dsf_pkg::READ_W-1:0] read_value;
		dsf_pkg::status_t           status;
		logic [dsf_pkg::OCC_W-1:0]  occupancy;
	} queue_result_t;

	class queue_scoreboard;
		logic [dsf_pkg::ITEM_W-1:0] held[QUEUE_DEPTH];
		int unsigned held_n;
		queue_result_t pending[$];
		int failures;

		function new();
			held_n = 0;
			failures = 0;
		endfunction

		function void report_fault(string msg);
			failures++;
			if (failures <= 10)
				$display("%s", msg);
		endfunction

		function void note_command(logic [dsf_pkg::CMD_W-1:0] cmd,
				logic [dsf_pkg::ITEM_W-1:0] value, logic [dsf_pkg::POS_W-1:0] pos);
			queue_result_t r;
			bit found;
			r.read_value = '0;
			r.status = dsf_pkg::ST_OK;
			case (cmd)
				dsf_pkg::CMD_ENQ: begin
					found = 0;
					for (int i = 0; i < held_n; i++)
						if (held[i] == value)
							found = 1;
					if (found)
						r.status = dsf_pkg::ST_DUP;
					else if (held_n >= QUEUE_DEPTH)
						r.status = dsf_pkg::ST_FULL;
					else begin
						held[held_n] = value;
						held_n++;
					end
				end
				dsf_pkg::CMD_DEQ: begin
					if (held_n == 0)
						r.status = dsf_pkg::ST_EMPTY;
					else begin
						r.read_value = held[0];
						for (int i = 0; i + 1 < held_n; i++)
							held[i] = held[i + 1];
						held_n--;
					end
				end
				dsf_pkg::CMD_PEEK: begin
					if (pos >= held_n)
						r.status = dsf_pkg::ST_RANGE;
					else
						r.read_value = held[pos];
				end
				default: ;
			endcase
			r.occupancy = held_n[dsf_pkg::OCC_W-1:0];
			pending.push_back(r);
		endfunction

		function void check_result(logic [dsf_pkg::READ_W-1:0] rv,
				logic [dsf_pkg::STAT_W-1:0] st, logic [dsf_pkg::OCC_W-1:0] occ);
			queue_result_t e;
			if (pending.size() == 0) begin
				report_fault($sformatf("Unexpected word: read %h status %0d occupancy %0d",
					rv, st, occ));
				return;
			end
			e = pending.pop_front();
			if (rv !== e.read_value || st !== e.status || occ !== e.occupancy)
				report_fault($sformatf(
					"Mismatch: expected read %h status %0d occupancy %0d, got %h %0d %0d",
					e.read_value, e.status, e.occupancy, rv, st, occ));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [dsf_pkg::S_TDATA_W-1:0] s_axis_tdata;
	logic [dsf_pkg::CMD_W-1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [dsf_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic [dsf_pkg::STAT_W-1:0] m_axis_tuser;

	queue_scoreboard book = new();
	bit sender_steady;
	logic [dsf_pkg::ITEM_W-1:0] value_pool[POOL_SIZE];

	dedup_shift_fifo_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

	task automatic send_command(input logic [dsf_pkg::CMD_W-1:0] cmd,
			input logic [dsf_pkg::ITEM_W-1:0] value, input logic [dsf_pkg::POS_W-1:0] pos);
		int unsigned gap;
		int unsigned roll;
		gap = 0;
		roll = $urandom_range(0, 99);
		if (!sender_steady) begin
			if (roll < 5)
				gap = $urandom_range(8, 40);
			else if (roll < 35)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(dsf_pkg::S_TDATA_W - dsf_pkg::ITEM_W - dsf_pkg::POS_W){1'b0}},
			pos, value};
		s_axis_tuser <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		book.note_command(cmd, value, pos);
	endtask

	task automatic wait_for_drain();
		s_axis_tvalid <= 1'b0;
		while (book.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned stall;
		int unsigned got;
		int unsigned roll;
		bit held_off;
		stall = 0;
		got = 0;
		held_off = 0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				book.check_result(m_axis_tdata[dsf_pkg::READ_W-1:0], m_axis_tuser,
					m_axis_tdata[dsf_pkg::READ_W+dsf_pkg::OCC_W-1:dsf_pkg::READ_W]);
				got++;
			end
			if (got >= HOLD_AT && !held_off) begin
				held_off = 1;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else if (got >= 400 && got < 600) begin
				m_axis_tready <= 1'b1;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 4)
					stall = $urandom_range(10, 40);
				else if (roll < 30)
					stall = $urandom_range(1, 3);
				m_axis_tready <= (stall == 0);
				if (stall > 0)
					stall--;
			end
		end
	end

	initial begin
		int unsigned fill_bias;
		int unsigned roll;
		logic [dsf_pkg::CMD_W-1:0] cmd;
		logic [dsf_pkg::ITEM_W-1:0] value;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		sender_steady = 0;
		fill_bias = 50;
		for (int i = 0; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;
		value_pool[0] = '0;
		value_pool[1] = '1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_command(dsf_pkg::CMD_PEEK, '0, '0);
		send_command(dsf_pkg::CMD_DEQ, '0, '0);
		send_command(CMD_SPARE, '1, '1);
		send_command(dsf_pkg::CMD_ENQ, '0, '0);
		send_command(dsf_pkg::CMD_ENQ, '1, '0);
		send_command(dsf_pkg::CMD_ENQ, '0, '1);
		send_command(dsf_pkg::CMD_PEEK, '0, 4'd1);
		send_command(dsf_pkg::CMD_PEEK, '0, 4'd2);
		send_command(dsf_pkg::CMD_DEQ, '0, '0);
		for (int i = 0; i < QUEUE_DEPTH - 1; i++)
			send_command(dsf_pkg::CMD_ENQ, 32'h1 << (2 * i + 1), '0);
		send_command(dsf_pkg::CMD_ENQ, 32'h8000_0000, '0);
		send_command(dsf_pkg::CMD_ENQ, '1, '0);
		send_command(dsf_pkg::CMD_PEEK, '0, 4'd15);
		send_command(dsf_pkg::CMD_PEEK, '0, '0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 80 == 0)
				fill_bias = $urandom_range(15, 85);
			sender_steady = (n >= 1300 && n < 1450);
			roll = $urandom_range(0, 99);
			if (roll < 4)
				cmd = CMD_SPARE;
			else if ($urandom_range(0, 99) < fill_bias)
				cmd = dsf_pkg::CMD_ENQ;
			else if ($urandom_range(0, 2) == 0)
				cmd = dsf_pkg::CMD_PEEK;
			else
				cmd = dsf_pkg::CMD_DEQ;
			if ($urandom_range(0, 3) == 0)
				value = $urandom;
			else
				value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
			send_command(cmd, value, dsf_pkg::POS_W'($urandom_range(0, 15)));
			if (n == 1100)
				wait_for_drain();
		end

		wait_for_drain();
		repeat (8) @(posedge clk);
		if (book.pending.size() != 0)
			book.report_fault("Results still outstanding at the end of the run");
		if (book.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
